### src/csvfs_pkg.sv
// Shared types and constants of the CSV field splitter.
`default_nettype none
package csvfs_pkg;

	localparam logic [7:0] QUOTE_BYTE    = 8'h22;
	localparam logic [7:0] COMMA_BYTE    = 8'h2C;
	localparam logic [7:0] MAX_SEP_RESET = 8'd32;

	typedef enum logic [1:0] {
		MODE_UNQUOTED = 2'd0,
		MODE_QUOTED   = 2'd1,
		MODE_PENDING  = 2'd2,
		MODE_SWALLOW  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE       = 2'd0,
		KIND_FIELD_END  = 2'd1,
		KIND_LINE_OK    = 2'd2,
		KIND_LINE_ERROR = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] character;
		logic       is_end;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] field_byte;
		logic [7:0] field_number;
	} result_t;

endpackage
`default_nettype wire

### src/csvfs_ifs.sv
// Channel interfaces: input bytes, results and the configuration write.
`default_nettype none
interface csvfs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       is_end;
	modport source (output valid, character, is_end, input ready);
	modport sink   (input valid, character, is_end, output ready);
endinterface

interface csvfs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] field_byte;
	logic [7:0] field_number;
	modport source (output valid, kind, field_byte, field_number, input ready);
	modport sink   (input valid, kind, field_byte, field_number, output ready);
endinterface

interface csvfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### src/csv_field_splitter_top.sv
// Top level of the CSV field splitter: input stage plus parser.
// An accepted byte is held in the input stage, then its result in the result register.
// Throughput: one item per cycle while the result channel is free; items that give no result never stall.
// Input stage and result register decouple the two channels.
// Reset (arst_n low, asynchronous): no items held, parser unquoted at
// field zero, max_separators back to 32.
`default_nettype none
module csv_field_splitter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	csvfs_char_if.sink       chars,
	csvfs_result_if.source   results,
	csvfs_cfg_if.sink        cfg
);

	logic              valid_s1;
	csvfs_pkg::item_t  item_s1;
	logic              consume;

	csvfs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	csvfs_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.consume  (consume),
		.results  (results),
		.cfg      (cfg)
	);

endmodule
`default_nettype wire

### src/csvfs_in_stage.sv
// Input register stage: holds one accepted byte item for the parser.
`default_nettype none
module csvfs_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	csvfs_char_if.sink           chars,
	input  wire logic            consume,
	output logic                 valid_s1,
	output csvfs_pkg::item_t     item_s1
);

	logic accept;

	assign chars.ready = !valid_s1 || consume;
	assign accept      = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.character <= chars.character;
			item_s1.is_end    <= chars.is_end;
		end
	end

	a_hold_until_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("input stage dropped or changed an item before it was consumed");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item not held in input stage");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> chars.ready)
		else $error("empty input stage refuses a request");

endmodule
`default_nettype wire

### src/csvfs_parse.sv
// Parse state, per-byte decision logic and the result output register.
`default_nettype none
module csvfs_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  csvfs_pkg::item_t     item_s1,
	output logic                 consume,
	csvfs_result_if.source       results,
	csvfs_cfg_if.sink            cfg
);

	csvfs_pkg::mode_t   mode_q, mode_d;
	logic               content_q, content_d;
	logic [7:0]         count_q, count_d;
	logic [7:0]         max_sep_q;
	logic               has_res;
	csvfs_pkg::result_t res;
	logic               out_valid_q;
	csvfs_pkg::result_t out_q;
	logic               out_free;
	logic               do_unq;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sep_q <= csvfs_pkg::MAX_SEP_RESET;
		end else if (cfg.valid) begin
			max_sep_q <= cfg.data;
		end
	end

	always_comb begin
		mode_d           = mode_q;
		content_d        = content_q;
		count_d          = count_q;
		has_res          = 1'b0;
		do_unq           = 1'b0;
		res.kind         = csvfs_pkg::KIND_BYTE;
		res.field_byte   = 8'd0;
		res.field_number = count_q;
		if (item_s1.is_end) begin
			has_res   = 1'b1;
			res.kind  = (mode_q == csvfs_pkg::MODE_QUOTED || mode_q == csvfs_pkg::MODE_SWALLOW)
			            ? csvfs_pkg::KIND_LINE_ERROR : csvfs_pkg::KIND_LINE_OK;
			mode_d    = csvfs_pkg::MODE_UNQUOTED;
			content_d = 1'b0;
			count_d   = 8'd0;
		end else begin
			unique case (mode_q)
				csvfs_pkg::MODE_QUOTED: begin
					if (item_s1.character == csvfs_pkg::QUOTE_BYTE) begin
						mode_d = csvfs_pkg::MODE_PENDING;
					end else begin
						content_d      = 1'b1;
						has_res        = 1'b1;
						res.field_byte = item_s1.character;
					end
				end
				csvfs_pkg::MODE_PENDING: begin
					if (item_s1.character == csvfs_pkg::QUOTE_BYTE) begin
						// doubled quote inside quotes: one literal quote
						mode_d         = csvfs_pkg::MODE_QUOTED;
						content_d      = 1'b1;
						has_res        = 1'b1;
						res.field_byte = csvfs_pkg::QUOTE_BYTE;
					end else begin
						mode_d = csvfs_pkg::MODE_UNQUOTED;
						do_unq = 1'b1;
					end
				end
				csvfs_pkg::MODE_SWALLOW: begin
					has_res = 1'b0;
				end
				default: begin
					do_unq = 1'b1;
				end
			endcase
			if (do_unq) begin
				if (item_s1.character == csvfs_pkg::COMMA_BYTE) begin
					if (count_q >= max_sep_q) begin
						mode_d = csvfs_pkg::MODE_SWALLOW;
					end else begin
						has_res   = 1'b1;
						res.kind  = csvfs_pkg::KIND_FIELD_END;
						count_d   = count_q + 8'd1;
						content_d = 1'b0;
					end
				end else if (item_s1.character == csvfs_pkg::QUOTE_BYTE && !content_q) begin
					mode_d = csvfs_pkg::MODE_QUOTED;
				end else begin
					content_d      = 1'b1;
					has_res        = 1'b1;
					res.field_byte = item_s1.character;
				end
			end
		end
	end

	// an item with no result never waits on the output side
	assign out_free = !out_valid_q || results.ready;
	assign consume  = valid_s1 && (!has_res || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= csvfs_pkg::MODE_UNQUOTED;
			content_q   <= 1'b0;
			count_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (consume) begin
				mode_q    <= mode_d;
				content_q <= content_d;
				count_q   <= count_d;
			end
			if (out_free) begin
				out_valid_q <= consume && has_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && has_res) begin
			out_q <= res;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kind         = out_q.kind;
	assign results.field_byte   = out_q.field_byte;
	assign results.field_number = out_q.field_number;

	a_result_presented: assert property (@(posedge clk) disable iff (!arst_n)
		consume && has_res |=> results.valid)
		else $error("result of a consumed item not presented");

	a_swallow_silent: assert property (@(posedge clk) disable iff (!arst_n)
		consume && mode_q == csvfs_pkg::MODE_SWALLOW
		|-> !has_res || res.kind == csvfs_pkg::KIND_LINE_ERROR)
		else $error("result produced while swallowing a rejected line");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.is_end
		|=> mode_q == csvfs_pkg::MODE_UNQUOTED && count_q == 8'd0 && !content_q)
		else $error("parse state not cleared after end of line");

	a_field_end_counts: assert property (@(posedge clk) disable iff (!arst_n)
		consume && has_res && res.kind == csvfs_pkg::KIND_FIELD_END
		|=> count_q == 8'($past(count_q) + 8'd1))
		else $error("separator count not advanced on field end");

endmodule
`default_nettype wire
